// File: rtl/fpba_pkg.sv
`timescale 1ns / 1ps

package fpba_pkg;

    // Default storage geometry
    localparam int NUM_BLOCKS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    // Port field widths
    localparam int IDX_W    = 4;
    localparam int AMOUNT_W = 16;
    localparam int CFG_W    = 5;

    // Configuration register indexes
    localparam logic CFG_FIT_MODE      = 1'b0;
    localparam logic CFG_BLOCKS_IN_USE = 1'b1;

    // Placement policies
    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_BEST  = 2'd1;
    localparam logic [1:0] MODE_WORST = 2'd2;
    localparam logic [1:0] MODE_NEXT  = 2'd3;

    // Request types
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_ALLOC = 1'b1;

    // Reset values of the configuration registers
    localparam logic [1:0]       FIT_MODE_RST      = MODE_FIRST;
    localparam logic [CFG_W-1:0] BLOCKS_IN_USE_RST = 5'd16;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;     // capture the accepted item, start a search
        logic load_wr;   // write the loaded size into the table
        logic issue;     // read the next table entry of the search
        logic wb;        // write back the reduced space of the pick
        logic out_load;  // move the result into the output register
    } fpba_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic count_zero;  // no block is searched
        logic last_issue;  // the current read is the last of the search
    } fpba_stat_t;

endpackage

// File: rtl/fpba_ram.sv
`timescale 1ns / 1ps

module fpba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/fpba_ctrl.sv
`timescale 1ns / 1ps

module fpba_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_req_type,
    output logic                m_valid,
    input  logic                m_ready,
    output fpba_pkg::fpba_cmd_t cmd,
    input  fpba_pkg::fpba_stat_t stat
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_WB,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    // Sequencing of one item and output register handshake
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.latch = 1'b1;
                    if (s_req_type == fpba_pkg::REQ_LOAD) begin
                        state_next = ST_LOAD;
                    end else if (stat.count_zero) begin
                        state_next = ST_WB;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_LOAD: begin
                cmd.load_wr = 1'b1;
                state_next  = ST_FIN;
            end
            ST_SCAN: begin
                cmd.issue = 1'b1;
                if (stat.last_issue) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last read data is judged here
                state_next = ST_WB;
            end
            ST_WB: begin
                cmd.wb     = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: rtl/fpba_dp.sv
`timescale 1ns / 1ps

module fpba_dp #(
    parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [fpba_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic [fpba_pkg::IDX_W-1:0]    s_load_index,
    input  logic [fpba_pkg::AMOUNT_W-1:0] s_amount,
    output logic                          m_granted,
    output logic [fpba_pkg::IDX_W-1:0]    m_chosen_block,
    output logic [fpba_pkg::AMOUNT_W-1:0] m_space_left,
    input  fpba_pkg::fpba_cmd_t           cmd,
    output fpba_pkg::fpba_stat_t          stat
);

    localparam int IW = $clog2(NUM_BLOCKS);
    localparam int CW = $clog2(NUM_BLOCKS + 1);
    localparam int BW = (CW > fpba_pkg::CFG_W) ? CW : fpba_pkg::CFG_W;
    localparam int AW = (SIZE_BITS > fpba_pkg::AMOUNT_W) ? SIZE_BITS : fpba_pkg::AMOUNT_W;

    // Configuration
    logic [1:0]                 fit_mode_reg;
    logic [fpba_pkg::CFG_W-1:0] blocks_in_use_reg;

    // Item and search state
    logic [fpba_pkg::IDX_W-1:0] load_idx_reg;
    logic [SIZE_BITS-1:0]       need_reg;
    logic [IW-1:0]              pos_reg;
    logic [CW-1:0]              kcnt_reg;
    logic                       eval_reg;
    logic [IW-1:0]              eval_pos_reg;
    logic                       rd_valid_reg;
    logic                       found_reg;
    logic [IW-1:0]              best_idx_reg;
    logic [SIZE_BITS-1:0]       best_val_reg;
    logic [IW-1:0]              rover_reg;
    logic [NUM_BLOCKS-1:0]      valid_reg;

    // Output register
    logic                          granted_reg;
    logic [fpba_pkg::IDX_W-1:0]    chosen_reg;
    logic [fpba_pkg::AMOUNT_W-1:0] space_reg;

    logic [BW-1:0]        biu_w;
    logic [CW-1:0]        count;
    logic [IW-1:0]        start_pos;
    logic [IW-1:0]        pos_wrap;
    logic [AW-1:0]        amt_w;
    logic [AW-1:0]        best_w;
    logic                 load_in_range;
    logic [SIZE_BITS-1:0] rd_data;
    logic [SIZE_BITS-1:0] cur_val;
    logic                 fits;
    logic                 take;
    logic                 ram_we;
    logic [IW-1:0]        ram_waddr;
    logic [SIZE_BITS-1:0] ram_wdata;
    logic [SIZE_BITS-1:0] diff;

    // Searched block count, saturated at the table depth
    assign biu_w = BW'(blocks_in_use_reg);
    assign count = (biu_w > BW'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS) : CW'(biu_w);

    assign stat.count_zero = (count == '0);
    assign stat.last_issue = (kcnt_reg == count - CW'(1));

    // Start and circular step of the search position
    assign start_pos = (fit_mode_reg == fpba_pkg::MODE_NEXT && CW'(rover_reg) < count) ?
                       rover_reg : '0;
    assign pos_wrap  = (CW'(pos_reg) + CW'(1) == count) ? '0 : pos_reg + IW'(1);

    // Amount masked to the entry width
    assign amt_w = AW'(s_amount);

    assign load_in_range = (32'(load_idx_reg) < 32'(NUM_BLOCKS));

    // Judge the entry returned by the table
    assign cur_val = rd_valid_reg ? rd_data : '0;
    assign fits    = (cur_val >= need_reg);

    always_comb begin
        take = 1'b0;
        if (eval_reg && fits) begin
            unique case (fit_mode_reg)
                fpba_pkg::MODE_FIRST: take = !found_reg;
                fpba_pkg::MODE_NEXT:  take = !found_reg;
                fpba_pkg::MODE_BEST:  take = !found_reg || (cur_val < best_val_reg);
                fpba_pkg::MODE_WORST: take = !found_reg || (cur_val > best_val_reg);
            endcase
        end
    end

    assign diff = best_val_reg - need_reg;

    // Table write: load or write-back of the pick
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = best_idx_reg;
        ram_wdata = diff;
        if (cmd.load_wr) begin
            ram_we    = load_in_range;
            ram_waddr = IW'(load_idx_reg);
            ram_wdata = need_reg;
        end else if (cmd.wb) begin
            ram_we = found_reg;
        end
    end

    fpba_ram #(
        .WIDTH(SIZE_BITS),
        .DEPTH(NUM_BLOCKS)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (cmd.issue),
        .raddr(pos_reg),
        .rdata(rd_data)
    );

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_mode_reg      <= fpba_pkg::FIT_MODE_RST;
            blocks_in_use_reg <= fpba_pkg::BLOCKS_IN_USE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                fpba_pkg::CFG_FIT_MODE:      fit_mode_reg      <= cfg_wdata[1:0];
                fpba_pkg::CFG_BLOCKS_IN_USE: blocks_in_use_reg <= cfg_wdata;
            endcase
        end
    end

    // Control state: entry valid bits, rover, read pipeline flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            rover_reg <= '0;
            eval_reg  <= 1'b0;
        end else begin
            eval_reg <= cmd.issue;
            if (ram_we) begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            if (cmd.wb && found_reg && fit_mode_reg == fpba_pkg::MODE_NEXT) begin
                rover_reg <= best_idx_reg;
            end
        end
    end

    // Item capture, search and result
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            load_idx_reg <= s_load_index;
            need_reg     <= amt_w[SIZE_BITS-1:0];
            pos_reg      <= start_pos;
            kcnt_reg     <= '0;
            found_reg    <= 1'b0;
        end
        if (cmd.issue) begin
            pos_reg      <= pos_wrap;
            kcnt_reg     <= kcnt_reg + CW'(1);
            eval_pos_reg <= pos_reg;
            rd_valid_reg <= valid_reg[pos_reg];
        end
        if (take) begin
            found_reg    <= 1'b1;
            best_idx_reg <= eval_pos_reg;
            best_val_reg <= cur_val;
        end
        if (cmd.wb) begin
            best_val_reg <= diff;
        end
        if (cmd.out_load) begin
            granted_reg <= found_reg;
            chosen_reg  <= found_reg ? fpba_pkg::IDX_W'(best_idx_reg) : '0;
            space_reg   <= found_reg ? best_w[fpba_pkg::AMOUNT_W-1:0] : '0;
        end
    end

    assign best_w = AW'(best_val_reg);

    assign m_granted      = granted_reg;
    assign m_chosen_block = chosen_reg;
    assign m_space_left   = space_reg;

endmodule

// File: rtl/fit_policy_block_allocator.sv
`timescale 1ns / 1ps

// Fit-policy block allocator.
// Input channel s_*: one item per handshake. A load item (req_type 0) sets the
// free space of block load_index to amount; an allocate item (req_type 1)
// asks for amount and gets one block picked by the fit_mode policy (first,
// best, worst or next fit), whose space is reduced by the request.
// Result channel m_*: exactly one item per input item, in order: granted,
// chosen_block and the space left in it; all zero for a load or a miss.
// Configuration: cfg_wr_en / cfg_index / cfg_wdata, written while idle.
// Sequence: a load writes the table, then moves its result to the output
// register; an allocation with no block searched goes straight to the
// write-back step; any other allocation scans the searched blocks of the
// free-space RAM serially, one read a cycle, then a drain and a write-back
// step before its result is moved out. One item is in work at a time; s_ready
// returns as the result enters the output register, so the next item can be
// accepted while that result is shown.
// Reset clears all block sizes to zero (per-entry valid bits), the next-fit
// rover to zero, fit_mode to first fit and blocks_in_use to 16.
// A stalled receiver holds the result in the output register; the block
// still takes and works one further item, then waits until that slot frees.
module fit_policy_block_allocator #(
    parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [fpba_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_req_type,
    input  logic [fpba_pkg::IDX_W-1:0]    s_load_index,
    input  logic [fpba_pkg::AMOUNT_W-1:0] s_amount,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_granted,
    output logic [fpba_pkg::IDX_W-1:0]    m_chosen_block,
    output logic [fpba_pkg::AMOUNT_W-1:0] m_space_left
);

    fpba_pkg::fpba_cmd_t  cmd;
    fpba_pkg::fpba_stat_t stat;

    fpba_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req_type(s_req_type),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    fpba_dp #(
        .NUM_BLOCKS(NUM_BLOCKS),
        .SIZE_BITS (SIZE_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_load_index  (s_load_index),
        .s_amount      (s_amount),
        .m_granted     (m_granted),
        .m_chosen_block(m_chosen_block),
        .m_space_left  (m_space_left),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

// File: verif/tb_fit_policy_block_allocator.sv
`timescale 1ns / 1ps

module tb_fit_policy_block_allocator;

    localparam int NB          = fpba_pkg::NUM_BLOCKS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_PHASES  = 10;
    localparam int PHASE_ITEMS = 80;
    localparam int SHOW_MAX    = 10;

    // One result item: grant flag, block picked and space left in it
    typedef struct packed {
        logic                          granted;
        logic [fpba_pkg::IDX_W-1:0]    block;
        logic [fpba_pkg::AMOUNT_W-1:0] space;
    } grant_t;

    // One row of the directed stimulus table
    typedef struct packed {
        logic                          req;
        logic [fpba_pkg::IDX_W-1:0]    idx;
        logic [fpba_pkg::AMOUNT_W-1:0] amt;
        logic [1:0]                    mode;
        logic [fpba_pkg::CFG_W-1:0]    nblk;
        logic                          has_lit;
        grant_t                        lit;
    } dir_row_t;

    logic                          aclk           = 1'b0;
    logic                          aresetn        = 1'b0;
    logic                          cfg_wr_en      = 1'b0;
    logic                          cfg_index      = fpba_pkg::CFG_FIT_MODE;
    logic [fpba_pkg::CFG_W-1:0]    cfg_wdata      = '0;
    logic                          s_valid        = 1'b0;
    logic                          s_ready;
    logic                          s_req_type     = fpba_pkg::REQ_LOAD;
    logic [fpba_pkg::IDX_W-1:0]    s_load_index   = '0;
    logic [fpba_pkg::AMOUNT_W-1:0] s_amount       = '0;
    logic                          m_valid;
    logic                          m_ready        = 1'b0;
    logic                          m_granted;
    logic [fpba_pkg::IDX_W-1:0]    m_chosen_block;
    logic [fpba_pkg::AMOUNT_W-1:0] m_space_left;

    // Predictor state and its copy of the configuration
    logic [fpba_pkg::AMOUNT_W-1:0] blk_space [NB];
    logic [fpba_pkg::IDX_W-1:0]    rover_pos;
    logic [1:0]                    mode_cfg;
    logic [fpba_pkg::CFG_W-1:0]    count_cfg;

    grant_t   grant_q [$];
    dir_row_t dir_tab [$];
    int       mismatch_cnt = 0;
    int       cycle_cnt    = 0;
    int       ready_hold   = 0;
    bit       no_idle      = 1'b0;

    fit_policy_block_allocator dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_load_index   (s_load_index),
        .s_amount       (s_amount),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_granted      (m_granted),
        .m_chosen_block (m_chosen_block),
        .m_space_left   (m_space_left)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int unsigned gap_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Request sizes spread over several scales, extremes included
    function automatic logic [fpba_pkg::AMOUNT_W-1:0] rand_amount();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        else if (r < 10)
            return '1;
        else if (r < 40)
            return fpba_pkg::AMOUNT_W'($urandom_range(0, 63));
        else if (r < 75)
            return fpba_pkg::AMOUNT_W'($urandom_range(0, 1023));
        return fpba_pkg::AMOUNT_W'($urandom);
    endfunction

    function automatic dir_row_t mk_row(logic req, logic [fpba_pkg::IDX_W-1:0] idx,
                                        logic [fpba_pkg::AMOUNT_W-1:0] amt,
                                        logic [1:0] mode,
                                        logic [fpba_pkg::CFG_W-1:0] nblk, logic has_lit,
                                        logic g, logic [fpba_pkg::IDX_W-1:0] b,
                                        logic [fpba_pkg::AMOUNT_W-1:0] s);
        dir_row_t row;
        row.req     = req;
        row.idx     = idx;
        row.amt     = amt;
        row.mode    = mode;
        row.nblk    = nblk;
        row.has_lit = has_lit;
        row.lit     = '{granted: g, block: b, space: s};
        return row;
    endfunction

    // Work out the result of one accepted item and update the table
    function automatic grant_t predict_grant(logic req, logic [fpba_pkg::IDX_W-1:0] idx,
                                             logic [fpba_pkg::AMOUNT_W-1:0] amt);
        grant_t      res;
        int unsigned count;
        int unsigned pos;
        int unsigned pick;
        bit          found;
        res   = '0;
        found = 1'b0;
        pick  = 0;
        if (req == fpba_pkg::REQ_LOAD) begin
            blk_space[idx] = amt;
            return res;
        end
        count = (count_cfg > NB) ? NB : count_cfg;
        if (mode_cfg == fpba_pkg::MODE_NEXT) begin
            // circular scan from the rover, restart at 0 if rover is out of range
            pos = (rover_pos < count) ? rover_pos : 0;
            for (int k = 0; k < count; k++) begin
                if (!found && blk_space[pos] >= amt) begin
                    found = 1'b1;
                    pick  = pos;
                end
                pos = (pos + 1 == count) ? 0 : pos + 1;
            end
        end else begin
            for (int k = 0; k < count; k++) begin
                if (blk_space[k] >= amt) begin
                    if (!found) begin
                        found = 1'b1;
                        pick  = k;
                    end else if (mode_cfg == fpba_pkg::MODE_BEST &&
                                 blk_space[k] < blk_space[pick]) begin
                        pick = k;
                    end else if (mode_cfg == fpba_pkg::MODE_WORST &&
                                 blk_space[k] > blk_space[pick]) begin
                        pick = k;
                    end
                end
            end
        end
        if (found) begin
            blk_space[pick] = blk_space[pick] - amt;
            if (mode_cfg == fpba_pkg::MODE_NEXT)
                rover_pos = fpba_pkg::IDX_W'(pick);
            res.granted = 1'b1;
            res.block   = fpba_pkg::IDX_W'(pick);
            res.space   = blk_space[pick];
        end
        return res;
    endfunction

    // Offer one item, hold it until taken, then queue what it should give
    task automatic send_request(logic req, logic [fpba_pkg::IDX_W-1:0] idx,
                                logic [fpba_pkg::AMOUNT_W-1:0] amt, logic has_lit,
                                grant_t lit);
        int unsigned gap;
        grant_t      pred;
        gap = no_idle ? 0 : gap_cycles();
        repeat (gap) begin
            @(negedge aclk);
            s_valid = 1'b0;
        end
        @(negedge aclk);
        s_valid      = 1'b1;
        s_req_type   = req;
        s_load_index = idx;
        s_amount     = amt;
        do @(posedge aclk); while (!s_ready);
        pred = predict_grant(req, idx, amt);
        grant_q.push_back(has_lit ? lit : pred);
    endtask

    // Stop sending and let every outstanding result come back
    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (grant_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [fpba_pkg::CFG_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        if (idx == fpba_pkg::CFG_FIT_MODE)
            mode_cfg = data[1:0];
        else
            count_cfg = data;
    endtask

    // Receiver: random stalls unless a no-idle stretch is running
    always @(negedge aclk) begin
        if (no_idle) begin
            m_ready    = 1'b1;
            ready_hold = 0;
        end else if (ready_hold > 0) begin
            ready_hold--;
        end else begin
            m_ready    = ($urandom_range(0, 3) != 0);
            ready_hold = gap_cycles();
        end
    end

    // Result checker and run watchdog
    always @(posedge aclk) begin
        grant_t got;
        grant_t want;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, grant_q.size());
            $display("status: fail");
            $finish;
        end else if (aresetn && m_valid && m_ready) begin
            got = '{granted: m_granted, block: m_chosen_block, space: m_space_left};
            if (grant_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= SHOW_MAX)
                    $display("unexpected item: granted=%0d block=%0d space=%0d",
                             got.granted, got.block, got.space);
            end else begin
                want = grant_q.pop_front();
                if (got.granted !== want.granted || got.block !== want.block ||
                    got.space !== want.space) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= SHOW_MAX)
                        $display({"mismatch: exp granted=%0d block=%0d space=%0d,",
                                  " got %0d %0d %0d"},
                                 want.granted, want.block, want.space,
                                 got.granted, got.block, got.space);
                end
            end
        end
    end

    initial begin
        logic [fpba_pkg::CFG_W-1:0] eff;
        logic [fpba_pkg::CFG_W-1:0] nblk;
        logic [1:0]                 mode;
        logic                       req;
        logic [fpba_pkg::IDX_W-1:0] idx;

        // predictor state after reset
        foreach (blk_space[i])
            blk_space[i] = '0;
        rover_pos = '0;
        mode_cfg  = fpba_pkg::FIT_MODE_RST;
        count_cfg = fpba_pkg::BLOCKS_IN_USE_RST;

        // directed table: literal results only where they are obvious
        dir_tab.push_back(mk_row(fpba_pkg::REQ_ALLOC, 0, 16'd1, fpba_pkg::MODE_FIRST,
                                 5'd16, 1, 0, 0, 0));
        dir_tab.push_back(mk_row(fpba_pkg::REQ_ALLOC, 0, 16'd0, fpba_pkg::MODE_FIRST,
                                 5'd16, 1, 1, 0, 0));
        dir_tab.push_back(mk_row(fpba_pkg::REQ_LOAD, 0, 16'hFFFF, fpba_pkg::MODE_FIRST,
                                 5'd16, 1, 0, 0, 0));
        dir_tab.push_back(mk_row(fpba_pkg::REQ_LOAD, 15, 16'd100, fpba_pkg::MODE_FIRST,
                                 5'd16, 1, 0, 0, 0));
        dir_tab.push_back(mk_row(fpba_pkg::REQ_LOAD, 5, 16'd300, fpba_pkg::MODE_FIRST,
                                 5'd16, 1, 0, 0, 0));
        dir_tab.push_back(mk_row(fpba_pkg::REQ_LOAD, 7, 16'd50, fpba_pkg::MODE_FIRST,
                                 5'd16, 1, 0, 0, 0));
        dir_tab.push_back(mk_row(fpba_pkg::REQ_LOAD, 3, 16'd300, fpba_pkg::MODE_FIRST,
                                 5'd16, 1, 0, 0, 0));
        dir_tab.push_back(mk_row(fpba_pkg::REQ_ALLOC, 0, 16'hFFFF, fpba_pkg::MODE_FIRST,
                                 5'd16, 1, 1, 0, 0));
        dir_tab.push_back(mk_row(fpba_pkg::REQ_ALLOC, 0, 16'd40, fpba_pkg::MODE_FIRST,
                                 5'd16, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(fpba_pkg::REQ_ALLOC, 0, 16'd40, fpba_pkg::MODE_BEST,
                                 5'd16, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(fpba_pkg::REQ_ALLOC, 0, 16'd10, fpba_pkg::MODE_WORST,
                                 5'd16, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(fpba_pkg::REQ_ALLOC, 0, 16'd5, fpba_pkg::MODE_NEXT,
                                 5'd16, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(fpba_pkg::REQ_ALLOC, 0, 16'd255, fpba_pkg::MODE_NEXT,
                                 5'd16, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(fpba_pkg::REQ_ALLOC, 0, 16'd200, fpba_pkg::MODE_NEXT,
                                 5'd16, 0, 0, 0, 0));
        // rover beyond the block count: the scan restarts at block 0
        dir_tab.push_back(mk_row(fpba_pkg::REQ_ALLOC, 0, 16'd1, fpba_pkg::MODE_NEXT,
                                 5'd4, 0, 0, 0, 0));
        // no block searched: every allocation misses
        dir_tab.push_back(mk_row(fpba_pkg::REQ_ALLOC, 0, 16'd0, fpba_pkg::MODE_NEXT,
                                 5'd0, 1, 0, 0, 0));
        dir_tab.push_back(mk_row(fpba_pkg::REQ_LOAD, 9, 16'hFFFF, fpba_pkg::MODE_FIRST,
                                 5'd0, 1, 0, 0, 0));
        // count above the table size saturates
        dir_tab.push_back(mk_row(fpba_pkg::REQ_ALLOC, 0, 16'hFFFF, fpba_pkg::MODE_WORST,
                                 5'd31, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(fpba_pkg::REQ_ALLOC, 0, 16'd0, fpba_pkg::MODE_BEST,
                                 5'd31, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(fpba_pkg::REQ_ALLOC, 0, 16'h8000, fpba_pkg::MODE_FIRST,
                                 5'd31, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(fpba_pkg::REQ_LOAD, 10, 16'hAAAA, fpba_pkg::MODE_FIRST,
                                 5'd31, 1, 0, 0, 0));
        dir_tab.push_back(mk_row(fpba_pkg::REQ_LOAD, 12, 16'h5555, fpba_pkg::MODE_FIRST,
                                 5'd31, 1, 0, 0, 0));
        dir_tab.push_back(mk_row(fpba_pkg::REQ_ALLOC, 0, 16'h5555, fpba_pkg::MODE_BEST,
                                 5'd16, 0, 0, 0, 0));
        dir_tab.push_back(mk_row(fpba_pkg::REQ_ALLOC, 0, 16'd1, fpba_pkg::MODE_NEXT,
                                 5'd1, 0, 0, 0, 0));

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed part
        foreach (dir_tab[i]) begin
            if (dir_tab[i].mode != mode_cfg || dir_tab[i].nblk != count_cfg) begin
                wait_drained();
                write_reg(fpba_pkg::CFG_FIT_MODE, fpba_pkg::CFG_W'(dir_tab[i].mode));
                write_reg(fpba_pkg::CFG_BLOCKS_IN_USE, dir_tab[i].nblk);
            end
            send_request(dir_tab[i].req, dir_tab[i].idx, dir_tab[i].amt,
                         dir_tab[i].has_lit, dir_tab[i].lit);
        end

        // random phases, each under its own setting
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            case (ph)
                0: nblk = 5'd16;
                1: nblk = 5'd1;
                2: nblk = 5'd31;
                3: nblk = 5'd0;
                4: nblk = 5'd2;
                default: begin
                    if ($urandom_range(0, 9) == 0)
                        nblk = fpba_pkg::CFG_W'($urandom_range(17, 31));
                    else
                        nblk = fpba_pkg::CFG_W'($urandom_range(1, 16));
                end
            endcase
            mode = (ph < 8) ? 2'(ph % 4) : 2'($urandom_range(0, 3));
            write_reg(fpba_pkg::CFG_FIT_MODE, fpba_pkg::CFG_W'(mode));
            write_reg(fpba_pkg::CFG_BLOCKS_IN_USE, nblk);
            no_idle = (ph == 5);
            eff = (count_cfg > NB) ? fpba_pkg::CFG_W'(NB) : count_cfg;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                req = ($urandom_range(0, 9) < 4) ? fpba_pkg::REQ_LOAD : fpba_pkg::REQ_ALLOC;
                // loads mostly land inside the searched range
                if (eff != 0 && $urandom_range(0, 3) != 0)
                    idx = fpba_pkg::IDX_W'($urandom_range(0, eff - 1));
                else
                    idx = fpba_pkg::IDX_W'($urandom_range(0, 15));
                send_request(req, idx, rand_amount(), 1'b0, '0);
                if ($urandom_range(0, 49) == 0)
                    wait_drained();
            end
        end
        no_idle = 1'b0;

        // let the last results come back
        @(negedge aclk);
        s_valid = 1'b0;
        while (grant_q.size() != 0)
            @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (mismatch_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: fit_policy_block_allocator.f
rtl/fpba_pkg.sv
rtl/fpba_ram.sv
rtl/fpba_ctrl.sv
rtl/fpba_dp.sv
rtl/fit_policy_block_allocator.sv
verif/tb_fit_policy_block_allocator.sv
